// ===== rtl/core/wrf_pkg.sv =====
// -----------------------------------------------------------------------------
// wrf_pkg
// Types, constants and score tables shared by the weighted risk fusion core.
// -----------------------------------------------------------------------------
package wrf_pkg;

   localparam int LEVEL_W  = 2;
   localparam int SCORE_W  = 16;
   localparam int TTC_W    = 16;
   localparam int CFG_W    = 16;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [LEVEL_W-1:0] {
      LEVEL_NORMAL    = 2'd0,
      LEVEL_HINT      = 2'd1,
      LEVEL_WARNING   = 2'd2,
      LEVEL_EMERGENCY = 2'd3
   } level_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WEIGHT_FRONT        = 3'd0,
      CSR_WEIGHT_REAR         = 3'd1,
      CSR_WEIGHT_DRIVER       = 3'd2,
      CSR_WEIGHT_IMU          = 3'd3,
      CSR_WEIGHT_HEART        = 3'd4,
      CSR_THRESHOLD_EMERGENCY = 3'd5,
      CSR_THRESHOLD_WARNING   = 3'd6,
      CSR_THRESHOLD_BRAKE     = 3'd7
   } csr_index_type;

   // register reset values (Q1.15)
   localparam logic [CFG_W-1:0] RST_WEIGHT_FRONT        = 16'd9830;
   localparam logic [CFG_W-1:0] RST_WEIGHT_REAR         = 16'd6554;
   localparam logic [CFG_W-1:0] RST_WEIGHT_DRIVER       = 16'd6554;
   localparam logic [CFG_W-1:0] RST_WEIGHT_IMU          = 16'd4915;
   localparam logic [CFG_W-1:0] RST_WEIGHT_HEART        = 16'd4915;
   localparam logic [CFG_W-1:0] RST_THRESHOLD_EMERGENCY = 16'd26214;
   localparam logic [CFG_W-1:0] RST_THRESHOLD_WARNING   = 16'd16384;
   localparam logic [CFG_W-1:0] RST_THRESHOLD_BRAKE     = 16'd29491;

   // fused score at or above which the level is at least hint
   localparam logic [SCORE_W-1:0] HINT_MIN_SCORE = 16'd8192;

   // time to collision breakpoints (ms)
   localparam logic [TTC_W-1:0] TTC_FAR_MS     = 16'd6000;
   localparam logic [TTC_W-1:0] TTC_MID_MS     = 16'd3000;
   localparam logic [TTC_W-1:0] TTC_NEAR_MS    = 16'd1500;
   localparam logic [TTC_W-1:0] TTC_INTERP_TOP = 16'd9000;

   localparam logic [SCORE_W-1:0] SCORE_ONE        = 16'd32768;
   localparam logic [SCORE_W-1:0] NEAR_FLOOR_SCORE = 16'd29491;

   // interpolation: (base * (9000 - ttc) + 3000) / 6000
   localparam int INTERP_X_W   = 13;
   localparam int INTERP_NUM_W = 28;
   localparam logic [INTERP_NUM_W-1:0] INTERP_ROUND = 28'd3000;
   // ceil(2^40 / 6000), exact for numerators below 2^28
   localparam int RECIP_6000_SHIFT = 40;
   localparam logic [INTERP_NUM_W-1:0] RECIP_6000 = 28'd183251938;

   // fused sum rounding
   localparam int FUSE_SHIFT = 15;
   localparam int FUSE_SUM_W = 35;
   localparam logic [FUSE_SUM_W-1:0] FUSE_ROUND = 35'd16384;

   // boost: (fused * 13 + 5) / 10, ceil(2^23 / 10) exact below 2^22
   localparam int BOOST_W = 20;
   localparam logic [BOOST_W-1:0] BOOST_MUL   = 20'd13;
   localparam logic [BOOST_W-1:0] BOOST_ROUND = 20'd5;
   localparam int RECIP_10_SHIFT = 23;
   localparam logic [BOOST_W-1:0] RECIP_10 = 20'd838861;

   typedef struct packed {
      logic [CFG_W-1:0] weight_front;
      logic [CFG_W-1:0] weight_rear;
      logic [CFG_W-1:0] weight_driver;
      logic [CFG_W-1:0] weight_imu;
      logic [CFG_W-1:0] weight_heart;
      logic [CFG_W-1:0] threshold_emergency;
      logic [CFG_W-1:0] threshold_warning;
      logic [CFG_W-1:0] threshold_brake;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] front_level;
      logic [TTC_W-1:0]   front_ttc_ms;
      logic               front_no_collision;
      logic [LEVEL_W-1:0] rear_level;
      logic [LEVEL_W-1:0] driver_level;
      logic [LEVEL_W-1:0] imu_level;
      logic [LEVEL_W-1:0] heart_level;
      logic               imu_abnormal;
   } item_type;

   typedef struct packed {
      logic [SCORE_W-1:0] front_score;
      logic [SCORE_W-1:0] rear_score;
      logic [SCORE_W-1:0] driver_score;
      logic [SCORE_W-1:0] imu_score;
      logic [SCORE_W-1:0] heart_score;
      logic               boost;
      logic               imu_abnormal;
   } score_type;

   typedef struct packed {
      score_type          scores;
      logic [SCORE_W-1:0] fused;
   } fused_type;

   typedef struct packed {
      score_type          scores;
      logic [SCORE_W-1:0] fused_score;
      level_type          overall_level;
      logic               warn_voice;
      logic               warn_vibrate;
      logic               brake_request;
   } result_type;

   function automatic logic [SCORE_W-1:0] level_score(input logic [LEVEL_W-1:0] lvl);
      logic [SCORE_W-1:0] s;
      case (lvl)
         LEVEL_NORMAL:    s = 16'd0;
         LEVEL_HINT:      s = 16'd9830;
         LEVEL_WARNING:   s = 16'd19661;
         LEVEL_EMERGENCY: s = 16'd32768;
         default:         s = 16'd0;
      endcase
      return s;
   endfunction

   // (base * 2 + 5) / 10
   function automatic logic [SCORE_W-1:0] no_coll_score(input logic [LEVEL_W-1:0] lvl);
      logic [SCORE_W-1:0] s;
      case (lvl)
         LEVEL_NORMAL:    s = 16'd0;
         LEVEL_HINT:      s = 16'd1966;
         LEVEL_WARNING:   s = 16'd3932;
         LEVEL_EMERGENCY: s = 16'd6554;
         default:         s = 16'd0;
      endcase
      return s;
   endfunction

   // (base * 3 + 5) / 10
   function automatic logic [SCORE_W-1:0] far_score(input logic [LEVEL_W-1:0] lvl);
      logic [SCORE_W-1:0] s;
      case (lvl)
         LEVEL_NORMAL:    s = 16'd0;
         LEVEL_HINT:      s = 16'd2949;
         LEVEL_WARNING:   s = 16'd5898;
         LEVEL_EMERGENCY: s = 16'd9830;
         default:         s = 16'd0;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/core/wrf_if.sv =====
// -----------------------------------------------------------------------------
// wrf_if
// Valid/ready channel interfaces: request, response and register write.
// -----------------------------------------------------------------------------
interface wrf_req_if;
   logic                         valid;
   logic                         ready;
   logic [wrf_pkg::LEVEL_W-1:0]  front_level;
   logic [wrf_pkg::TTC_W-1:0]    front_ttc_ms;
   logic                         front_no_collision;
   logic [wrf_pkg::LEVEL_W-1:0]  rear_level;
   logic [wrf_pkg::LEVEL_W-1:0]  driver_level;
   logic [wrf_pkg::LEVEL_W-1:0]  imu_level;
   logic [wrf_pkg::LEVEL_W-1:0]  heart_level;
   logic                         imu_abnormal;

   modport source (output valid, front_level, front_ttc_ms, front_no_collision, rear_level,
                   driver_level, imu_level, heart_level, imu_abnormal, input ready);
   modport sink   (input valid, front_level, front_ttc_ms, front_no_collision, rear_level,
                   driver_level, imu_level, heart_level, imu_abnormal, output ready);
endinterface

interface wrf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [wrf_pkg::SCORE_W-1:0]  front_score;
   logic [wrf_pkg::SCORE_W-1:0]  rear_score;
   logic [wrf_pkg::SCORE_W-1:0]  driver_score;
   logic [wrf_pkg::SCORE_W-1:0]  imu_score;
   logic [wrf_pkg::SCORE_W-1:0]  heart_score;
   logic [wrf_pkg::SCORE_W-1:0]  fused_score;
   logic [wrf_pkg::LEVEL_W-1:0]  overall_level;
   logic                         warn_voice;
   logic                         warn_vibrate;
   logic                         brake_request;

   modport source (output valid, front_score, rear_score, driver_score, imu_score,
                   heart_score, fused_score, overall_level, warn_voice, warn_vibrate,
                   brake_request, input ready);
   modport sink   (input valid, front_score, rear_score, driver_score, imu_score,
                   heart_score, fused_score, overall_level, warn_voice, warn_vibrate,
                   brake_request, output ready);
endinterface

interface wrf_csr_if;
   logic                          valid;
   logic                          ready;
   logic [wrf_pkg::CSR_IDX_W-1:0] index;
   logic [wrf_pkg::CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/wrf_csr.sv =====
// -----------------------------------------------------------------------------
// wrf_csr
// Weight and threshold registers, written through the register channel.
// -----------------------------------------------------------------------------
module wrf_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_valid,
   output logic                          wr_ready,
   input  logic [wrf_pkg::CSR_IDX_W-1:0] wr_index,
   input  logic [wrf_pkg::CFG_W-1:0]     wr_data,
   output wrf_pkg::cfg_type              cfg
);

   wrf_pkg::cfg_type cfg_ff, cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (wrf_pkg::csr_index_type'(wr_index))
            wrf_pkg::CSR_WEIGHT_FRONT:        cfg_in.weight_front        = wr_data;
            wrf_pkg::CSR_WEIGHT_REAR:         cfg_in.weight_rear         = wr_data;
            wrf_pkg::CSR_WEIGHT_DRIVER:       cfg_in.weight_driver       = wr_data;
            wrf_pkg::CSR_WEIGHT_IMU:          cfg_in.weight_imu          = wr_data;
            wrf_pkg::CSR_WEIGHT_HEART:        cfg_in.weight_heart        = wr_data;
            wrf_pkg::CSR_THRESHOLD_EMERGENCY: cfg_in.threshold_emergency = wr_data;
            wrf_pkg::CSR_THRESHOLD_WARNING:   cfg_in.threshold_warning   = wr_data;
            wrf_pkg::CSR_THRESHOLD_BRAKE:     cfg_in.threshold_brake     = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.weight_front        <= wrf_pkg::RST_WEIGHT_FRONT;
         cfg_ff.weight_rear         <= wrf_pkg::RST_WEIGHT_REAR;
         cfg_ff.weight_driver       <= wrf_pkg::RST_WEIGHT_DRIVER;
         cfg_ff.weight_imu          <= wrf_pkg::RST_WEIGHT_IMU;
         cfg_ff.weight_heart        <= wrf_pkg::RST_WEIGHT_HEART;
         cfg_ff.threshold_emergency <= wrf_pkg::RST_THRESHOLD_EMERGENCY;
         cfg_ff.threshold_warning   <= wrf_pkg::RST_THRESHOLD_WARNING;
         cfg_ff.threshold_brake     <= wrf_pkg::RST_THRESHOLD_BRAKE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/wrf_front.sv =====
// -----------------------------------------------------------------------------
// wrf_front
// Stages 1-2: level scores, front score modulation by time to collision.
// -----------------------------------------------------------------------------
module wrf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  wrf_pkg::item_type  in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output wrf_pkg::score_type out_scores
);

   typedef struct packed {
      wrf_pkg::score_type                  scores;   // front_score holds the fixed value
      logic                                use_interp;
      logic [wrf_pkg::INTERP_NUM_W-1:0]    interp_num;
   } front_stage_type;

   localparam int PROD_W = 2 * wrf_pkg::INTERP_NUM_W;

   front_stage_type                   a_ff, a_in;
   logic                              a_valid_ff;
   logic                              a_ready;
   wrf_pkg::score_type                b_ff, b_in;
   logic                              b_valid_ff;
   logic                              b_ready;

   logic [wrf_pkg::SCORE_W-1:0]       base;
   logic [wrf_pkg::TTC_W-1:0]         ttc_gap;
   logic [PROD_W-1:0]                 quot_prod;

   assign a_ready  = !a_valid_ff || b_ready;
   assign b_ready  = !b_valid_ff || out_ready;
   assign in_ready = a_ready;

   // stage 1: table lookups, range select, interpolation numerator
   always_comb begin
      base    = wrf_pkg::level_score(in_item.front_level);
      ttc_gap = wrf_pkg::TTC_INTERP_TOP - in_item.front_ttc_ms;

      a_in.scores.rear_score   = wrf_pkg::level_score(in_item.rear_level);
      a_in.scores.driver_score = wrf_pkg::level_score(in_item.driver_level);
      a_in.scores.imu_score    = wrf_pkg::level_score(in_item.imu_level);
      a_in.scores.heart_score  = wrf_pkg::level_score(in_item.heart_level);
      a_in.scores.boost        = in_item.driver_level[1] && in_item.heart_level[1];
      a_in.scores.imu_abnormal = in_item.imu_abnormal;
      a_in.use_interp          = 1'b0;
      a_in.interp_num = ({{(wrf_pkg::INTERP_NUM_W - wrf_pkg::SCORE_W){1'b0}}, base} *
                         {{(wrf_pkg::INTERP_NUM_W - wrf_pkg::INTERP_X_W){1'b0}},
                          ttc_gap[wrf_pkg::INTERP_X_W-1:0]}) + wrf_pkg::INTERP_ROUND;

      if (in_item.front_no_collision) begin
         a_in.scores.front_score = wrf_pkg::no_coll_score(in_item.front_level);
      end else if (in_item.front_ttc_ms > wrf_pkg::TTC_FAR_MS) begin
         a_in.scores.front_score = wrf_pkg::far_score(in_item.front_level);
      end else if (in_item.front_ttc_ms > wrf_pkg::TTC_MID_MS) begin
         a_in.scores.front_score = base;
         a_in.use_interp         = 1'b1;
      end else if (in_item.front_ttc_ms > wrf_pkg::TTC_NEAR_MS) begin
         a_in.scores.front_score = base;
      end else if (in_item.front_level == wrf_pkg::LEVEL_EMERGENCY) begin
         a_in.scores.front_score = wrf_pkg::SCORE_ONE;
      end else begin
         a_in.scores.front_score = wrf_pkg::NEAR_FLOOR_SCORE;
      end
   end

   // stage 2: divide by 6000 through reciprocal multiply
   always_comb begin
      quot_prod = {{wrf_pkg::INTERP_NUM_W{1'b0}}, a_ff.interp_num} *
                  {{wrf_pkg::INTERP_NUM_W{1'b0}}, wrf_pkg::RECIP_6000};
      b_in = a_ff.scores;
      if (a_ff.use_interp) begin
         b_in.front_score = quot_prod[wrf_pkg::RECIP_6000_SHIFT +: wrf_pkg::SCORE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) a_ff <= a_in;
      if (b_ready) b_ff <= b_in;
   end

   assign out_valid  = b_valid_ff;
   assign out_scores = b_ff;

endmodule

// ===== rtl/core/wrf_fuse.sv =====
// -----------------------------------------------------------------------------
// wrf_fuse
// Stages 3-4: five weighted products, rounded sum saturated to 16 bits.
// -----------------------------------------------------------------------------
module wrf_fuse (
   input  logic               clock,
   input  logic               reset,
   input  wrf_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  wrf_pkg::score_type in_scores,
   output logic               out_valid,
   input  logic               out_ready,
   output wrf_pkg::fused_type out_fused
);

   localparam int PROD_W = wrf_pkg::CFG_W + wrf_pkg::SCORE_W;
   localparam int NUM_TERMS = 5;

   logic [PROD_W-1:0]             prod_ff [NUM_TERMS];
   logic [PROD_W-1:0]             prod_in [NUM_TERMS];
   wrf_pkg::score_type            c_scores_ff;
   logic                          c_valid_ff;
   logic                          c_ready;
   wrf_pkg::fused_type            d_ff, d_in;
   logic                          d_valid_ff;
   logic                          d_ready;

   logic [wrf_pkg::FUSE_SUM_W-1:0] sum;
   logic [wrf_pkg::FUSE_SUM_W-1:0] shifted;

   assign c_ready  = !c_valid_ff || d_ready;
   assign d_ready  = !d_valid_ff || out_ready;
   assign in_ready = c_ready;

   always_comb begin
      prod_in[0] = {{wrf_pkg::SCORE_W{1'b0}}, cfg.weight_front} *
                   {{wrf_pkg::CFG_W{1'b0}}, in_scores.front_score};
      prod_in[1] = {{wrf_pkg::SCORE_W{1'b0}}, cfg.weight_rear} *
                   {{wrf_pkg::CFG_W{1'b0}}, in_scores.rear_score};
      prod_in[2] = {{wrf_pkg::SCORE_W{1'b0}}, cfg.weight_driver} *
                   {{wrf_pkg::CFG_W{1'b0}}, in_scores.driver_score};
      prod_in[3] = {{wrf_pkg::SCORE_W{1'b0}}, cfg.weight_imu} *
                   {{wrf_pkg::CFG_W{1'b0}}, in_scores.imu_score};
      prod_in[4] = {{wrf_pkg::SCORE_W{1'b0}}, cfg.weight_heart} *
                   {{wrf_pkg::CFG_W{1'b0}}, in_scores.heart_score};
   end

   always_comb begin
      sum = wrf_pkg::FUSE_ROUND;
      for (int i = 0; i < NUM_TERMS; i++) begin
         sum = sum + {{(wrf_pkg::FUSE_SUM_W - PROD_W){1'b0}}, prod_ff[i]};
      end
      shifted = sum >> wrf_pkg::FUSE_SHIFT;
      d_in.scores = c_scores_ff;
      if (|shifted[wrf_pkg::FUSE_SUM_W-1:wrf_pkg::SCORE_W]) begin
         d_in.fused = {wrf_pkg::SCORE_W{1'b1}};
      end else begin
         d_in.fused = shifted[wrf_pkg::SCORE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (c_ready) c_valid_ff <= in_valid;
         if (d_ready) d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready) begin
         prod_ff     <= prod_in;
         c_scores_ff <= in_scores;
      end
      if (d_ready) d_ff <= d_in;
   end

   assign out_valid = d_valid_ff;
   assign out_fused = d_ff;

endmodule

// ===== rtl/core/wrf_decide.sv =====
// -----------------------------------------------------------------------------
// wrf_decide
// Stages 5-6: driver/heart boost, level thresholds and warning flags.
// Stage 6 is the response output register.
// -----------------------------------------------------------------------------
module wrf_decide #(
   parameter logic [wrf_pkg::SCORE_W-1:0] HINT_MIN_SCORE = wrf_pkg::HINT_MIN_SCORE
) (
   input  logic                clock,
   input  logic                reset,
   input  wrf_pkg::cfg_type    cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  wrf_pkg::fused_type  in_fused,
   output logic                out_valid,
   input  logic                out_ready,
   output wrf_pkg::result_type out_result
);

   localparam int PROD_W = 2 * wrf_pkg::BOOST_W;
   localparam int QUOT_W = PROD_W - wrf_pkg::RECIP_10_SHIFT;

   logic [PROD_W-1:0]          e_prod_ff, e_prod_in;
   wrf_pkg::fused_type         e_ff;
   logic                       e_valid_ff;
   logic                       e_ready;
   wrf_pkg::result_type        f_ff, f_in;
   logic                       f_valid_ff;
   logic                       f_ready;

   logic [wrf_pkg::BOOST_W-1:0] boost_num;
   logic [QUOT_W-1:0]           boost_quot;
   logic [wrf_pkg::SCORE_W-1:0] final_score;

   assign e_ready  = !e_valid_ff || f_ready;
   assign f_ready  = !f_valid_ff || out_ready;
   assign in_ready = e_ready;

   // stage 5: (fused * 13 + 5) times reciprocal of 10
   always_comb begin
      boost_num = {{(wrf_pkg::BOOST_W - wrf_pkg::SCORE_W){1'b0}}, in_fused.fused} *
                  wrf_pkg::BOOST_MUL + wrf_pkg::BOOST_ROUND;
      e_prod_in = {{wrf_pkg::BOOST_W{1'b0}}, boost_num} *
                  {{wrf_pkg::BOOST_W{1'b0}}, wrf_pkg::RECIP_10};
   end

   // stage 6: cap, thresholds, flags
   always_comb begin
      boost_quot = e_prod_ff[PROD_W-1:wrf_pkg::RECIP_10_SHIFT];
      if (!e_ff.scores.boost) begin
         final_score = e_ff.fused;
      end else if (boost_quot > {{(QUOT_W - wrf_pkg::SCORE_W){1'b0}}, wrf_pkg::SCORE_ONE}) begin
         final_score = wrf_pkg::SCORE_ONE;
      end else begin
         final_score = boost_quot[wrf_pkg::SCORE_W-1:0];
      end

      f_in.scores      = e_ff.scores;
      f_in.fused_score = final_score;
      if (final_score >= cfg.threshold_emergency) begin
         f_in.overall_level = wrf_pkg::LEVEL_EMERGENCY;
      end else if (final_score >= cfg.threshold_warning) begin
         f_in.overall_level = wrf_pkg::LEVEL_WARNING;
      end else if (final_score >= HINT_MIN_SCORE) begin
         f_in.overall_level = wrf_pkg::LEVEL_HINT;
      end else begin
         f_in.overall_level = wrf_pkg::LEVEL_NORMAL;
      end
      f_in.warn_voice    = (f_in.overall_level != wrf_pkg::LEVEL_NORMAL);
      f_in.warn_vibrate  = (f_in.overall_level == wrf_pkg::LEVEL_WARNING) ||
                           (f_in.overall_level == wrf_pkg::LEVEL_EMERGENCY);
      f_in.brake_request = (final_score >= cfg.threshold_brake) && !e_ff.scores.imu_abnormal;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         if (e_ready) e_valid_ff <= in_valid;
         if (f_ready) f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (e_ready) begin
         e_prod_ff <= e_prod_in;
         e_ff      <= in_fused;
      end
      if (f_ready) f_ff <= f_in;
   end

   assign out_valid  = f_valid_ff;
   assign out_result = f_ff;

endmodule

// ===== rtl/core/weighted_risk_fusion_core.sv =====
// -----------------------------------------------------------------------------
// weighted_risk_fusion_core
// Fuses five sensor risk levels into a weighted Q1.15 score, overall level
// and warning / brake flags.
//
//   channel   role      content
//   req_bus   sink      five risk levels, front ttc (ms), no-collision, abnormal
//   rsp_bus   source    five scores, fused score, overall level, three flags
//   csr_bus   sink      register index and 16-bit write data, always ready
//
// Six register stages; a beat accepted on req_bus passes through all six in order
// and is then presented on rsp_bus.
// One beat per cycle sustained while rsp_bus is ready.
// Each stage holds while its successor is full and stalled, so bubbles close up
// and a stalled response does not stop new request beats until all stages fill.
// Reset clears all stage valids and loads the register defaults.
// -----------------------------------------------------------------------------
module weighted_risk_fusion_core #(
   parameter logic [wrf_pkg::SCORE_W-1:0] HINT_MIN_SCORE = wrf_pkg::HINT_MIN_SCORE
) (
   input  logic      clock,
   input  logic      reset,
   wrf_req_if.sink   req_bus,
   wrf_rsp_if.source rsp_bus,
   wrf_csr_if.sink   csr_bus
);

   wrf_pkg::cfg_type    cfg;
   wrf_pkg::item_type   item;
   wrf_pkg::score_type  scores;
   wrf_pkg::fused_type  fused;
   wrf_pkg::result_type result;

   logic front_valid, front_ready;
   logic fuse_valid, fuse_ready;

   assign item.front_level        = req_bus.front_level;
   assign item.front_ttc_ms       = req_bus.front_ttc_ms;
   assign item.front_no_collision = req_bus.front_no_collision;
   assign item.rear_level         = req_bus.rear_level;
   assign item.driver_level       = req_bus.driver_level;
   assign item.imu_level          = req_bus.imu_level;
   assign item.heart_level        = req_bus.heart_level;
   assign item.imu_abnormal       = req_bus.imu_abnormal;

   wrf_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_bus.valid),
      .wr_ready (csr_bus.ready),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .cfg      (cfg)
   );

   wrf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .in_item    (item),
      .out_valid  (front_valid),
      .out_ready  (front_ready),
      .out_scores (scores)
   );

   wrf_fuse u_fuse (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_scores (scores),
      .out_valid (fuse_valid),
      .out_ready (fuse_ready),
      .out_fused (fused)
   );

   wrf_decide #(
      .HINT_MIN_SCORE (HINT_MIN_SCORE)
   ) u_decide (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (fuse_valid),
      .in_ready   (fuse_ready),
      .in_fused   (fused),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_result (result)
   );

   assign rsp_bus.front_score   = result.scores.front_score;
   assign rsp_bus.rear_score    = result.scores.rear_score;
   assign rsp_bus.driver_score  = result.scores.driver_score;
   assign rsp_bus.imu_score     = result.scores.imu_score;
   assign rsp_bus.heart_score   = result.scores.heart_score;
   assign rsp_bus.fused_score   = result.fused_score;
   assign rsp_bus.overall_level = result.overall_level;
   assign rsp_bus.warn_voice    = result.warn_voice;
   assign rsp_bus.warn_vibrate  = result.warn_vibrate;
   assign rsp_bus.brake_request = result.brake_request;

endmodule
